FILE: hw/rtl/edj_pkg.sv
// Package for the Euler rotation matrix and Jacobian unit.
// Holds command codes, CORDIC constants and the Q1.30 arithmetic helpers.
package edj_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int ENTRY_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 24;
  localparam int STEPS_PER_STG  = 4;
  localparam int CORDIC_STAGES  = CORDIC_STEPS / STEPS_PER_STG;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic signed [63:0] Q30_HALF    = 64'sd536870912;

  typedef enum logic [1:0] {
    CMD_ROT   = 2'd0,
    CMD_ROLL  = 2'd1,
    CMD_PITCH = 2'd2,
    CMD_YAW   = 2'd3
  } cmd_t;

  // One CORDIC lane value: x, y, residual angle and the final flip flag.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
  } cordic_t;

  function automatic logic signed [33:0] atan_tab(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh20000000;
      5'd1:  r = 34'sh12E4051E;
      5'd2:  r = 34'sh09FB385B;
      5'd3:  r = 34'sh051111D4;
      5'd4:  r = 34'sh028B0D43;
      5'd5:  r = 34'sh0145D7E1;
      5'd6:  r = 34'sh00A2F61E;
      5'd7:  r = 34'sh00517C55;
      5'd8:  r = 34'sh0028BE53;
      5'd9:  r = 34'sh00145F2F;
      5'd10: r = 34'sh000A2F98;
      5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6;
      5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2FA;
      5'd15: r = 34'sh0000517D;
      5'd16: r = 34'sh000028BE;
      5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A30;
      5'd19: r = 34'sh00000518;
      5'd20: r = 34'sh0000028C;
      5'd21: r = 34'sh00000146;
      5'd22: r = 34'sh000000A3;
      5'd23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // One rotation-mode CORDIC step; arithmetic shifts floor as required.
  function automatic cordic_t cordic_step(input cordic_t v, input logic [4:0] i);
    cordic_t o;
    logic signed [33:0] dx, dy;
    o  = v;
    dx = v.y >>> i;
    dy = v.x >>> i;
    if (!v.z[33]) begin
      o.x = v.x - dx;
      o.y = v.y + dy;
      o.z = v.z - atan_tab(i);
    end else begin
      o.x = v.x + dx;
      o.y = v.y - dy;
      o.z = v.z + atan_tab(i);
    end
    return o;
  endfunction

  // Q1.30 product, rounded half up.
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'(Q30_HALF);
    return p[63:30];
  endfunction

endpackage

FILE: hw/rtl/edj_cordic.sv
// Pipelined sine/cosine CORDIC for one binary angle, Q1.30 outputs.
// Depends on edj_pkg; one word enters per cycle under the shared enable.
module edj_cordic #(
  parameter int ANGLE_BITS = edj_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [33:0]           sin_q30,
  output logic signed [33:0]           cos_q30
);
  import edj_pkg::*;

  cordic_t stg_r [CORDIC_STAGES+1];
  cordic_t seed;
  logic [31:0] a32, a_rot;
  logic [31:0] qtest;

  // Place the angle in a 32-bit binary angle and fold into [-pi/2, pi/2).
  always_comb begin
    a32   = {angle, {(32-ANGLE_BITS){1'b0}}};
    qtest = a32 + 32'h4000_0000;
    seed.flip = qtest[31];
    a_rot = seed.flip ? a32 + 32'h8000_0000 : a32;
    seed.x = CORDIC_GAIN;
    seed.y = '0;
    seed.z = {{2{a_rot[31]}}, a_rot};
  end

  always_ff @(posedge clk) begin
    if (en) stg_r[0] <= seed;
  end

  // Four iterations in each register stage.
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stg
    cordic_t v [STEPS_PER_STG+1];
    always_comb begin
      v[0] = stg_r[s];
      for (int k = 0; k < STEPS_PER_STG; k++)
        v[k+1] = cordic_step(v[k], 5'(s*STEPS_PER_STG + k));
    end
    always_ff @(posedge clk) begin
      if (en) stg_r[s+1] <= v[STEPS_PER_STG];
    end
  end

  assign sin_q30 = stg_r[CORDIC_STAGES].flip ? -stg_r[CORDIC_STAGES].y
                                             : stg_r[CORDIC_STAGES].y;
  assign cos_q30 = stg_r[CORDIC_STAGES].flip ? -stg_r[CORDIC_STAGES].x
                                             : stg_r[CORDIC_STAGES].x;
endmodule

FILE: hw/rtl/edj_matrix.sv
// Product and sum stages that form the matrix from the sines and cosines.
// Depends on edj_pkg; three register stages under the shared enable.
module edj_matrix #(
  parameter int ENTRY_BITS = edj_pkg::ENTRY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  edj_pkg::cmd_t                cmd,
  input  logic signed [33:0]           sp, cp, st, ct, sy, cy,
  output logic signed [ENTRY_BITS-1:0] m [9]
);
  import edj_pkg::*;

  localparam int SH = 32 - ENTRY_BITS;
  localparam logic signed [35:0] HI = 36'sd2**(ENTRY_BITS-1) - 36'sd1;
  localparam logic signed [35:0] LO = -HI - 36'sd1;

  // Stage A: pair products of roll and pitch.
  logic signed [33:0] spst_r, cpst_r, spct_r, cpct_r;
  logic signed [33:0] a_sp_r, a_cp_r, a_st_r, a_ct_r, a_sy_r, a_cy_r;
  cmd_t               a_cmd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      spst_r <= mul_q30(sp, st);
      cpst_r <= mul_q30(cp, st);
      spct_r <= mul_q30(sp, ct);
      cpct_r <= mul_q30(cp, ct);
      a_sp_r <= sp; a_cp_r <= cp; a_st_r <= st; a_ct_r <= ct;
      a_sy_r <= sy; a_cy_r <= cy;
      a_cmd_r <= cmd;
    end
  end

  // Stage B: every product with a yaw term.
  logic signed [33:0] p_r [16];
  logic signed [33:0] b_st_r, b_ct_r, b_spst_r, b_cpst_r, b_spct_r, b_cpct_r;
  cmd_t               b_cmd_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= mul_q30(a_ct_r, a_cy_r);
      p_r[1]  <= mul_q30(a_ct_r, a_sy_r);
      p_r[2]  <= mul_q30(spst_r, a_cy_r);
      p_r[3]  <= mul_q30(spst_r, a_sy_r);
      p_r[4]  <= mul_q30(a_cp_r, a_sy_r);
      p_r[5]  <= mul_q30(a_cp_r, a_cy_r);
      p_r[6]  <= mul_q30(cpst_r, a_cy_r);
      p_r[7]  <= mul_q30(cpst_r, a_sy_r);
      p_r[8]  <= mul_q30(a_sp_r, a_sy_r);
      p_r[9]  <= mul_q30(a_sp_r, a_cy_r);
      p_r[10] <= mul_q30(a_st_r, a_cy_r);
      p_r[11] <= mul_q30(a_st_r, a_sy_r);
      p_r[12] <= mul_q30(spct_r, a_cy_r);
      p_r[13] <= mul_q30(spct_r, a_sy_r);
      p_r[14] <= mul_q30(cpct_r, a_cy_r);
      p_r[15] <= mul_q30(cpct_r, a_sy_r);
      b_st_r <= a_st_r; b_ct_r <= a_ct_r;
      b_spst_r <= spst_r; b_cpst_r <= cpst_r;
      b_spct_r <= spct_r; b_cpct_r <= cpct_r;
      b_cmd_r <= a_cmd_r;
    end
  end

  // Stage C: select by command, sum, round and saturate.
  logic signed [35:0] e [9];
  logic signed [ENTRY_BITS-1:0] m_nxt [9];
  always_comb begin
    for (int k = 0; k < 9; k++) e[k] = '0;
    case (b_cmd_r)
      CMD_ROT: begin
        e[0] = 36'(p_r[0]);
        e[1] = 36'(p_r[1]);
        e[2] = -36'(b_st_r);
        e[3] = 36'(p_r[2]) - 36'(p_r[4]);
        e[4] = 36'(p_r[3]) + 36'(p_r[5]);
        e[5] = 36'(b_spct_r);
        e[6] = 36'(p_r[6]) + 36'(p_r[8]);
        e[7] = 36'(p_r[7]) - 36'(p_r[9]);
        e[8] = 36'(b_cpct_r);
      end
      CMD_ROLL: begin
        e[3] = 36'(p_r[6]) + 36'(p_r[8]);
        e[4] = 36'(p_r[7]) - 36'(p_r[9]);
        e[5] = 36'(b_cpct_r);
        e[6] = 36'(p_r[4]) - 36'(p_r[2]);
        e[7] = -36'(p_r[3]) - 36'(p_r[5]);
        e[8] = -36'(b_spct_r);
      end
      CMD_PITCH: begin
        e[0] = -36'(p_r[10]);
        e[1] = -36'(p_r[11]);
        e[2] = -36'(b_ct_r);
        e[3] = 36'(p_r[12]);
        e[4] = 36'(p_r[13]);
        e[5] = -36'(b_spst_r);
        e[6] = 36'(p_r[14]);
        e[7] = 36'(p_r[15]);
        e[8] = -36'(b_cpst_r);
      end
      CMD_YAW: begin
        e[0] = -36'(p_r[1]);
        e[1] = 36'(p_r[0]);
        e[3] = -36'(p_r[3]) - 36'(p_r[5]);
        e[4] = 36'(p_r[2]) - 36'(p_r[4]);
        e[6] = 36'(p_r[9]) - 36'(p_r[7]);
        e[7] = 36'(p_r[6]) + 36'(p_r[8]);
      end
      default: ;
    endcase
    for (int k = 0; k < 9; k++) begin
      logic signed [36:0] r;
      if (SH > 0) r = (37'(e[k]) + (37'sd1 <<< (SH > 0 ? SH-1 : 0))) >>> SH;
      else        r = 37'(e[k]);
      if (r > 37'(HI))      m_nxt[k] = HI[ENTRY_BITS-1:0];
      else if (r < 37'(LO)) m_nxt[k] = LO[ENTRY_BITS-1:0];
      else                  m_nxt[k] = r[ENTRY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) m <= m_nxt;
  end
endmodule

FILE: hw/rtl/euler_dcm_and_jacobians_unit.sv
// ZYX Euler rotation matrix and its roll/pitch/yaw Jacobians, Q1.14 entries.
// Pipeline: 7 CORDIC register stages and 3 matrix stages from accepted word to result.
// Throughput: one word per cycle; the whole pipeline advances when the output is free.
// Reset: rst_n synchronous active low clears the valid bits only.
// Depends on edj_pkg, edj_cordic and edj_matrix.
module euler_dcm_and_jacobians_unit #(
  parameter int ANGLE_BITS = edj_pkg::ANGLE_BITS_DEF,
  parameter int ENTRY_BITS = edj_pkg::ENTRY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_command,
  input  logic signed [ANGLE_BITS-1:0] in_roll_angle,
  input  logic signed [ANGLE_BITS-1:0] in_pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] in_yaw_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ENTRY_BITS-1:0] out_m00, out_m01, out_m02,
  output logic signed [ENTRY_BITS-1:0] out_m10, out_m11, out_m12,
  output logic signed [ENTRY_BITS-1:0] out_m20, out_m21, out_m22
);
  import edj_pkg::*;

  localparam int LAT = CORDIC_STAGES + 1 + 3;

  logic              en;
  logic [LAT-1:0]    vld_r;
  cmd_t              cmd_r [CORDIC_STAGES+1];
  logic signed [33:0] sp, cp, st, ct, sy, cy;
  logic signed [ENTRY_BITS-1:0] m [9];

  // Pipeline moves whenever the last stage is empty or being taken.
  assign en       = !vld_r[LAT-1] || out_ready;
  assign in_ready = en;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Command rides alongside the CORDIC stages.
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[0] <= cmd_t'(in_command);
      for (int k = 1; k <= CORDIC_STAGES; k++) cmd_r[k] <= cmd_r[k-1];
    end
  end

  edj_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk(clk), .en(en), .angle(in_roll_angle), .sin_q30(sp), .cos_q30(cp));
  edj_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk(clk), .en(en), .angle(in_pitch_angle), .sin_q30(st), .cos_q30(ct));
  edj_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk(clk), .en(en), .angle(in_yaw_angle), .sin_q30(sy), .cos_q30(cy));

  edj_matrix #(.ENTRY_BITS(ENTRY_BITS)) u_matrix (
    .clk(clk), .en(en), .cmd(cmd_r[CORDIC_STAGES]),
    .sp(sp), .cp(cp), .st(st), .ct(ct), .sy(sy), .cy(cy), .m(m));

  assign out_valid = vld_r[LAT-1];
  assign out_m00 = m[0];
  assign out_m01 = m[1];
  assign out_m02 = m[2];
  assign out_m10 = m[3];
  assign out_m11 = m[4];
  assign out_m12 = m[5];
  assign out_m20 = m[6];
  assign out_m21 = m[7];
  assign out_m22 = m[8];
endmodule

FILE: bench/testbench.sv
// Testbench for euler_dcm_and_jacobians_unit: ZYX rotation matrix and its Jacobians.
// Relies on edj_pkg for the command codes; predicts every matrix with its own CORDIC model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import edj_pkg::*;

  typedef logic [8:0][15:0] matrix_t;

  localparam longint GAIN_Q30 = 64'sd652032875;
  localparam longint HALF_Q30 = 64'sd536870912;
  localparam int PIPE_DEPTH = 10;
  localparam int STALL_LIMIT = 1000;
  localparam longint ARCTAN_Q30 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic signed [15:0] in_roll_angle, in_pitch_angle, in_yaw_angle;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [15:0] out_m20, out_m21, out_m22;

  matrix_t expected_matrices[$];
  int fail_count;
  int idle_cycles;
  bit steady;

  euler_dcm_and_jacobians_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_roll_angle(in_roll_angle), .in_pitch_angle(in_pitch_angle),
    .in_yaw_angle(in_yaw_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22)
  );

  // Free-running clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Sine and cosine in Q1.30 by rotation-mode CORDIC, with the half-turn fold.
  function automatic void cordic_sincos(input logic [15:0] ang, output longint s,
                                        output longint c);
    logic [31:0] a;
    bit flip;
    longint x, y, z, dx, dy;
    a = {ang, 16'h0000};
    flip = 1'b0;
    if (32'(a + 32'h4000_0000) >= 32'h8000_0000) begin
      a = a + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'(signed'(a));
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_Q30[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_Q30[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + HALF_Q30) >>> 30;
  endfunction

  // Round to Q1.14 and saturate.
  function automatic logic [15:0] to_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic matrix_t euler_matrix(input cmd_t cmd, input logic [15:0] roll,
                                           input logic [15:0] pitch, input logic [15:0] yaw);
    longint sp, cp, st, ct, sy, cy, spst, cpst, spct, cpct;
    longint m [9];
    matrix_t res;
    cordic_sincos(roll, sp, cp);
    cordic_sincos(pitch, st, ct);
    cordic_sincos(yaw, sy, cy);
    spst = q30_mul(sp, st);
    cpst = q30_mul(cp, st);
    spct = q30_mul(sp, ct);
    cpct = q30_mul(cp, ct);
    case (cmd)
      CMD_ROT: begin
        m[0] = q30_mul(ct, cy);
        m[1] = q30_mul(ct, sy);
        m[2] = -st;
        m[3] = q30_mul(spst, cy) - q30_mul(cp, sy);
        m[4] = q30_mul(spst, sy) + q30_mul(cp, cy);
        m[5] = spct;
        m[6] = q30_mul(cpst, cy) + q30_mul(sp, sy);
        m[7] = q30_mul(cpst, sy) - q30_mul(sp, cy);
        m[8] = cpct;
      end
      CMD_ROLL: begin
        m[0] = 0;
        m[1] = 0;
        m[2] = 0;
        m[3] = q30_mul(cpst, cy) + q30_mul(sp, sy);
        m[4] = q30_mul(cpst, sy) - q30_mul(sp, cy);
        m[5] = cpct;
        m[6] = -q30_mul(spst, cy) + q30_mul(cp, sy);
        m[7] = -q30_mul(spst, sy) - q30_mul(cp, cy);
        m[8] = -spct;
      end
      CMD_PITCH: begin
        m[0] = -q30_mul(st, cy);
        m[1] = -q30_mul(st, sy);
        m[2] = -ct;
        m[3] = q30_mul(spct, cy);
        m[4] = q30_mul(spct, sy);
        m[5] = -spst;
        m[6] = q30_mul(cpct, cy);
        m[7] = q30_mul(cpct, sy);
        m[8] = -cpst;
      end
      default: begin
        m[0] = -q30_mul(ct, sy);
        m[1] = q30_mul(ct, cy);
        m[2] = 0;
        m[3] = -q30_mul(spst, sy) - q30_mul(cp, cy);
        m[4] = q30_mul(spst, cy) - q30_mul(cp, sy);
        m[5] = 0;
        m[6] = -q30_mul(cpst, sy) + q30_mul(sp, cy);
        m[7] = q30_mul(cpst, cy) + q30_mul(sp, sy);
        m[8] = 0;
      end
    endcase
    for (int k = 0; k < 9; k++) res[k] = to_q14(m[k]);
    return res;
  endfunction

  // Send one word after a random gap (none in steady mode) and record the matrix it must produce.
  task automatic send_angles(input cmd_t cmd, input logic [15:0] roll,
                             input logic [15:0] pitch, input logic [15:0] yaw);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_roll_angle <= roll;
    in_pitch_angle <= pitch;
    in_yaw_angle <= yaw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_matrices.push_back(euler_matrix(cmd, roll, pitch, yaw));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  // Angle biased toward the fold boundaries and the range ends.
  function automatic logic [15:0] pick_angle();
    logic [15:0] edges [8] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000,
                               16'hC000, 16'h3FFF, 16'hBFFF, 16'hFFFF};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 7)];
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    logic [15:0] corners [6] = '{16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'hBFFF};
    for (int c = 0; c < 4; c++) begin
      send_angles(cmd_t'(c), corners[c], corners[c + 1], corners[c + 2]);
      send_angles(cmd_t'(c), 16'h2000, 16'hE000, 16'h5555);
    end
    // Pitch at and beside plus and minus a quarter turn, where the fold switches, then the range ends.
    send_angles(CMD_ROT, 16'h0000, 16'h4000, 16'h0000);
    send_angles(CMD_PITCH, 16'h3FFF, 16'hC000, 16'h4000);
    send_angles(CMD_ROLL, 16'hC000, 16'h3FFF, 16'h8000);
    send_angles(CMD_YAW, 16'h7FFF, 16'h8000, 16'hFFFF);
    send_angles(CMD_YAW, 16'h0001, 16'hFFFF, 16'h7FFF);
    send_angles(CMD_ROT, 16'h8000, 16'h8000, 16'h8000);
    send_angles(CMD_PITCH, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_angles(CMD_ROLL, 16'hFFFF, 16'h0001, 16'h4001);
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++)
      send_angles(cmd_t'($urandom_range(0, 3)), pick_angle(), pick_angle(), pick_angle());
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    test_random(40);
    steady = 1'b0;
  endtask

  // Output side: accept results with random stalls (none in steady mode) and compare each entry.
  int stall;
  always @(posedge clk) begin
    matrix_t want, got;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_m22, out_m21, out_m20, out_m12, out_m11, out_m10, out_m02, out_m01, out_m00};
        if (expected_matrices.size() == 0) begin
          $display("%0t: unexpected word, got %p", $time, got);
          fail_count++;
        end else begin
          want = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want[k]) begin
              $display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
                       $signed(want[k]), $signed(got[k]));
              fail_count++;
            end
        end
      end
      if (out_valid && out_ready) begin
        if (!steady && $urandom_range(0, 1) == 1) begin
          stall <= $urandom_range(1, 6);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end else if (stall > 1) begin
        stall <= stall - 1;
      end else begin
        stall <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_ROT;
    in_roll_angle = '0;
    in_pitch_angle = '0;
    in_yaw_angle = '0;
    fail_count = 0;
    idle_cycles = 0;
    steady = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(300);
    wait_drained();
    test_back_to_back();
    test_random(300);
    wait_drained();
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
